// ----- src/ots_pkg.sv -----
`default_nettype none
package ots_pkg;

   localparam int unsigned PACKET_BYTES_DEF = 2048;

   // Event codes
   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_TICK  = 3'd1;
   localparam logic [2:0] OP_RESP  = 3'd2;
   localparam logic [2:0] OP_LINK  = 3'd3;
   localparam logic [2:0] OP_ABORT = 3'd4;

   // Response message codes
   localparam logic [2:0] MSG_START  = 3'd0;
   localparam logic [2:0] MSG_HEADER = 3'd1;
   localparam logic [2:0] MSG_PACKET = 3'd2;
   localparam logic [2:0] MSG_STATUS = 3'd3;
   localparam logic [2:0] MSG_UPG    = 3'd4;

   localparam logic [2:0] TS_PROC = 3'd1;
   localparam logic [2:0] TS_DONE = 3'd2;
   localparam logic [2:0] TS_ERR  = 3'd3;

   localparam logic [1:0] MS_READY = 2'd0;
   localparam logic [1:0] MS_BOUND = 2'd1;

   // Commands
   localparam logic [2:0] CMD_NONE   = 3'd0;
   localparam logic [2:0] CMD_PWR_ON = 3'd1;
   localparam logic [2:0] CMD_START  = 3'd2;
   localparam logic [2:0] CMD_HEADER = 3'd3;
   localparam logic [2:0] CMD_PACKET = 3'd4;
   localparam logic [2:0] CMD_QUERY  = 3'd5;
   localparam logic [2:0] CMD_STOP   = 3'd6;
   localparam logic [2:0] CMD_PWR_OFF = 3'd7;

   localparam logic [1:0] OC_BUSY = 2'd0;
   localparam logic [1:0] OC_OK   = 2'd1;
   localparam logic [1:0] OC_FAIL = 2'd2;

   localparam logic [3:0] FC_NONE     = 4'd0;
   localparam logic [3:0] FC_LINK     = 4'd1;
   localparam logic [3:0] FC_TIMEOUT  = 4'd2;
   localparam logic [3:0] FC_OPEN     = 4'd3;
   localparam logic [3:0] FC_START    = 4'd4;
   localparam logic [3:0] FC_HEADER   = 4'd5;
   localparam logic [3:0] FC_PACKET   = 4'd6;
   localparam logic [3:0] FC_ID       = 4'd7;
   localparam logic [3:0] FC_STATUS   = 4'd8;
   localparam logic [3:0] FC_STAT_UNX = 4'd9;
   localparam logic [3:0] FC_NEXT_ID  = 4'd10;
   localparam logic [3:0] FC_UPGRADE  = 4'd11;

   // Register indexes
   localparam logic [2:0] REG_IMAGE   = 3'd0;
   localparam logic [2:0] REG_HEADER  = 3'd1;
   localparam logic [2:0] REG_OPEN_TO = 3'd2;
   localparam logic [2:0] REG_REPLY_TO = 3'd3;
   localparam logic [2:0] REG_SETTLE  = 3'd4;
   localparam logic [2:0] REG_UPG_TO  = 3'd5;

   localparam logic [18:0] WAIT_MAX = 19'd524287;
   localparam logic [13:0] PKT_MAX  = 14'd8192;

   // Classified event handed from front to back
   typedef struct packed {
      logic [2:0]  op;
      logic        is_note;
      logic [2:0]  msg;
      logic        ok;
      logic        mstat_good;
      logic        echo_hi_zero;
      logic [12:0] echo_lo;
      logic [2:0]  tstat;
      logic [12:0] wanted;
      logic        upok;
   } event_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [12:0] packet_number;
      logic [23:0] payload_offset;
      logic [11:0] payload_length;
      logic [13:0] packet_count;
      logic [1:0]  outcome;
      logic [3:0]  fail_cause;
      logic        last;
   } result_type;

endpackage
`default_nettype wire

// ----- src/ots_front.sv -----
`default_nettype none
module ots_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [2:0]           req_operation,
   input  wire logic                 req_resp_is_note,
   input  wire logic [2:0]           req_resp_message,
   input  wire logic                 req_resp_ok,
   input  wire logic [1:0]           req_module_status,
   input  wire logic [31:0]          req_echoed_packet,
   input  wire logic [2:0]           req_transfer_status,
   input  wire logic [12:0]          req_wanted_packet,
   input  wire logic                 req_upgrade_ok,
   output      logic                 evt_valid,
   input  wire logic                 evt_ready,
   output      ots_pkg::event_type   evt_data
);
   // Two-entry queue between front and back
   ots_pkg::event_type q_ff [2];
   ots_pkg::event_type cls;
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   always_comb begin
      cls.op           = req_operation;
      cls.is_note      = req_resp_is_note;
      cls.msg          = req_resp_message;
      cls.ok           = req_resp_ok;
      cls.mstat_good   = (req_module_status == ots_pkg::MS_READY) ||
                         (req_module_status == ots_pkg::MS_BOUND);
      cls.echo_hi_zero = (req_echoed_packet[31:13] == 19'd0);
      cls.echo_lo      = req_echoed_packet[12:0];
      cls.tstat        = req_transfer_status;
      cls.wanted       = req_wanted_packet;
      cls.upok         = req_upgrade_ok;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign evt_valid = (cnt_ff != 2'd0);
   assign pop       = evt_valid && evt_ready;
   assign evt_data  = q_ff[rp_ff];
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= cls;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> (wp_ff == rp_ff)) else $error("empty queue pointers differ");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> (wp_ff == rp_ff)) else $error("full queue pointers differ");
endmodule
`default_nettype wire

// ----- src/ots_back.sv -----
`default_nettype none
module ots_back #(
   parameter int unsigned PACKET_BYTES = ots_pkg::PACKET_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 evt_valid,
   output      logic                 evt_ready,
   input  wire ots_pkg::event_type   evt_data,
   input  wire logic                 csr_write,
   input  wire logic [2:0]           csr_index,
   input  wire logic [23:0]          csr_data,
   output      logic                 out_valid,
   input  wire logic                 out_ready,
   output      ots_pkg::result_type  out_data
);
   localparam int unsigned PB_SHIFT = $clog2(PACKET_BYTES);
   localparam logic [24:0] PB_M1 = 25'(PACKET_BYTES - 1);
   localparam logic [11:0] PB_LEN = (PACKET_BYTES > 4095) ? 12'd4095 : 12'(PACKET_BYTES);

   localparam logic [3:0] PH_IDLE = 4'd0, PH_OPENING = 4'd1, PH_SETTLE = 4'd2,
      PH_STARTING = 4'd3, PH_HEADER = 4'd4, PH_PACKET = 4'd5, PH_STATUS = 4'd6,
      PH_UPGRADE = 4'd7, PH_DONE = 4'd8, PH_FAIL_EARLY = 4'd9, PH_FAIL_LATE = 4'd10;

   logic [23:0] image_ff;
   logic [15:0] header_ff, open_to_ff, reply_to_ff, settle_ff;
   logic [18:0] upg_to_ff;
   logic [3:0]  phase_ff, phase_in;
   logic [12:0] cur_ff, cur_in;
   logic [13:0] total_ff, total_in;
   logic [18:0] wait_ff, wait_in;
   logic [23:0] fw_ff;

   // Output: two result slots, second used only by abort
   ots_pkg::result_type r0_ff, r1_ff, r0_in, r1_in;
   logic       v0_ff, v1_ff;
   logic [1:0] n_in;

   ots_pkg::event_type e;
   logic        take;
   logic [18:0] wc;
   logic [18:0] limit;
   logic [12:0] nxt;
   logic        nxt_lt;
   logic        good;
   logic [36:0] pstart;
   logic [24:0] total_raw;

   assign e = evt_data;
   assign evt_ready = !v0_ff || (out_ready && !v1_ff);
   assign take = evt_valid && evt_ready;
   assign out_valid = v0_ff;
   assign out_data  = r0_ff;

   // Configuration registers; the firmware size register below follows them
   always_ff @(posedge clock) begin
      if (reset) begin
         image_ff    <= 24'd0;
         header_ff   <= 16'd0;
         open_to_ff  <= 16'd2000;
         reply_to_ff <= 16'd1000;
         settle_ff   <= 16'd1000;
         upg_to_ff   <= 19'd300000;
      end else if (csr_write) begin
         unique case (csr_index)
            ots_pkg::REG_IMAGE:    image_ff    <= csr_data;
            ots_pkg::REG_HEADER:   header_ff   <= csr_data[15:0];
            ots_pkg::REG_OPEN_TO:  open_to_ff  <= csr_data[15:0];
            ots_pkg::REG_REPLY_TO: reply_to_ff <= csr_data[15:0];
            ots_pkg::REG_SETTLE:   settle_ff   <= csr_data[15:0];
            ots_pkg::REG_UPG_TO:   upg_to_ff   <= csr_data[18:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      fw_ff <= (image_ff > {8'd0, header_ff}) ? (image_ff - {8'd0, header_ff}) : 24'd0;
   end

   function automatic ots_pkg::result_type mk(input logic [2:0] cmd,
                                             input logic [1:0] oc,
                                             input logic [3:0] cause);
      ots_pkg::result_type r;
      r = '0;
      r.command = cmd;
      r.outcome = oc;
      r.fail_cause = cause;
      return r;
   endfunction

   always_comb begin
      logic [36:0] remain;
      logic [11:0] len;
      logic [3:0]  fph;
      logic        do_pkt, do_fail;
      logic [3:0]  cause;

      phase_in = phase_ff;
      cur_in   = cur_ff;
      total_in = total_ff;
      wait_in  = wait_ff;
      r0_in    = '0;
      r1_in    = '0;
      n_in     = 2'd0;
      do_pkt   = 1'b0;
      do_fail  = 1'b0;
      cause    = ots_pkg::FC_NONE;
      wc       = (wait_ff < ots_pkg::WAIT_MAX) ? wait_ff + 19'd1 : wait_ff;
      limit    = (phase_ff == PH_OPENING) ? {3'd0, open_to_ff} :
                 (phase_ff == PH_UPGRADE) ? upg_to_ff : {3'd0, reply_to_ff};
      nxt      = cur_ff + 13'd1;
      nxt_lt   = ({1'b0, cur_ff} + 14'd1) < total_ff;
      good     = !e.is_note && e.ok;
      total_raw = ({1'b0, fw_ff} + PB_M1) >> PB_SHIFT;
      fph      = (phase_ff == PH_OPENING) ? PH_FAIL_EARLY : PH_FAIL_LATE;

      unique case (e.op)
         ots_pkg::OP_START: begin
            if (phase_ff == PH_IDLE) begin
               phase_in = PH_OPENING;
               wait_in  = 19'd0;
               r0_in    = mk(ots_pkg::CMD_PWR_ON, ots_pkg::OC_BUSY, ots_pkg::FC_NONE);
               n_in     = 2'd1;
            end
         end
         ots_pkg::OP_TICK: begin
            if (phase_ff >= PH_OPENING && phase_ff <= PH_UPGRADE) begin
               wait_in = wc;
               if (phase_ff == PH_SETTLE) begin
                  if (wc >= {3'd0, settle_ff}) begin
                     phase_in = PH_STARTING;
                     wait_in  = 19'd0;
                     r0_in    = mk(ots_pkg::CMD_START, ots_pkg::OC_BUSY, ots_pkg::FC_NONE);
                     n_in     = 2'd1;
                  end
               end else if (wc >= limit) begin
                  if (phase_ff == PH_PACKET) begin
                     phase_in = PH_STATUS;
                     wait_in  = 19'd0;
                     r0_in    = mk(ots_pkg::CMD_QUERY, ots_pkg::OC_BUSY, ots_pkg::FC_NONE);
                     n_in     = 2'd1;
                  end else begin
                     do_fail = 1'b1;
                     cause   = ots_pkg::FC_TIMEOUT;
                  end
               end
            end
         end
         ots_pkg::OP_RESP: begin
            unique case (phase_ff)
               PH_OPENING: begin
                  if (!e.is_note || !e.mstat_good) begin
                     do_fail = 1'b1; cause = ots_pkg::FC_OPEN;
                  end else begin
                     phase_in = PH_SETTLE;
                     wait_in  = 19'd0;
                  end
               end
               PH_STARTING: begin
                  if (!good || e.msg != ots_pkg::MSG_START) begin
                     do_fail = 1'b1; cause = ots_pkg::FC_START;
                  end else begin
                     total_in = (total_raw > {11'd0, ots_pkg::PKT_MAX}) ?
                                ots_pkg::PKT_MAX : total_raw[13:0];
                     cur_in   = 13'd0;
                     phase_in = PH_HEADER;
                     wait_in  = 19'd0;
                     r0_in    = mk(ots_pkg::CMD_HEADER, ots_pkg::OC_BUSY, ots_pkg::FC_NONE);
                     r0_in.packet_count = total_in;
                     n_in     = 2'd1;
                  end
               end
               PH_HEADER: begin
                  if (!good || e.msg != ots_pkg::MSG_HEADER) begin
                     do_fail = 1'b1; cause = ots_pkg::FC_HEADER;
                  end else do_pkt = 1'b1;
               end
               PH_PACKET: begin
                  if (!good || e.msg != ots_pkg::MSG_PACKET) begin
                     do_fail = 1'b1; cause = ots_pkg::FC_PACKET;
                  end else if (!e.echo_hi_zero || e.echo_lo != cur_ff) begin
                     do_fail = 1'b1; cause = ots_pkg::FC_ID;
                  end else if (nxt_lt) begin
                     cur_in = nxt; do_pkt = 1'b1;
                  end else begin
                     phase_in = PH_UPGRADE; wait_in = 19'd0;
                  end
               end
               PH_STATUS: begin
                  if (!good || e.msg != ots_pkg::MSG_STATUS || e.tstat > ots_pkg::TS_ERR) begin
                     do_fail = 1'b1; cause = ots_pkg::FC_STATUS;
                  end else if (e.tstat == ots_pkg::TS_DONE) begin
                     phase_in = PH_DONE;
                     r0_in    = mk(ots_pkg::CMD_NONE, ots_pkg::OC_OK, ots_pkg::FC_NONE);
                     n_in     = 2'd1;
                  end else if (e.tstat != ots_pkg::TS_PROC) begin
                     do_fail = 1'b1; cause = ots_pkg::FC_STAT_UNX;
                  end else if (e.wanted == cur_ff) begin
                     do_pkt = 1'b1;
                  end else if (e.wanted != nxt || ({1'b0, cur_ff} + 14'd1) > 14'd8191) begin
                     do_fail = 1'b1; cause = ots_pkg::FC_NEXT_ID;
                  end else if (nxt_lt) begin
                     cur_in = nxt; do_pkt = 1'b1;
                  end else begin
                     phase_in = PH_UPGRADE; wait_in = 19'd0;
                  end
               end
               PH_UPGRADE: begin
                  if (!e.is_note || e.msg != ots_pkg::MSG_UPG || !e.upok) begin
                     do_fail = 1'b1; cause = ots_pkg::FC_UPGRADE;
                  end else begin
                     phase_in = PH_DONE;
                     r0_in    = mk(ots_pkg::CMD_NONE, ots_pkg::OC_OK, ots_pkg::FC_NONE);
                     n_in     = 2'd1;
                  end
               end
               default: ;
            endcase
         end
         ots_pkg::OP_LINK: begin
            if (phase_ff == PH_OPENING ||
                (phase_ff >= PH_STARTING && phase_ff <= PH_UPGRADE)) begin
               do_fail = 1'b1; cause = ots_pkg::FC_LINK;
            end
         end
         ots_pkg::OP_ABORT: begin
            if (phase_ff != PH_IDLE) begin
               if ((phase_ff > PH_OPENING && phase_ff < PH_DONE) ||
                   phase_ff == PH_FAIL_LATE) begin
                  r0_in = mk(ots_pkg::CMD_STOP, ots_pkg::OC_BUSY, ots_pkg::FC_NONE);
                  r1_in = mk(ots_pkg::CMD_PWR_OFF, ots_pkg::OC_BUSY, ots_pkg::FC_NONE);
                  n_in  = 2'd2;
               end else begin
                  r0_in = mk(ots_pkg::CMD_PWR_OFF, ots_pkg::OC_BUSY, ots_pkg::FC_NONE);
                  n_in  = 2'd1;
               end
               phase_in = PH_IDLE;
               wait_in  = 19'd0;
            end
         end
         default: ;
      endcase

      // Packet offset and length from the packet number that goes out
      pstart = 37'(cur_in) << PB_SHIFT;
      remain = {13'd0, fw_ff} - pstart;
      if (pstart < {13'd0, fw_ff})
         len = (remain > 37'(PB_LEN)) ? PB_LEN : remain[11:0];
      else
         len = 12'd0;
      if (do_pkt) begin
         phase_in = PH_PACKET;
         wait_in  = 19'd0;
         r0_in    = mk(ots_pkg::CMD_PACKET, ots_pkg::OC_BUSY, ots_pkg::FC_NONE);
         r0_in.packet_number  = cur_in;
         r0_in.payload_offset = {8'd0, header_ff} + pstart[23:0];
         r0_in.payload_length = len;
         n_in     = 2'd1;
      end
      if (do_fail) begin
         phase_in = fph;
         r0_in    = mk(ots_pkg::CMD_NONE, ots_pkg::OC_FAIL, cause);
         n_in     = 2'd1;
      end
      r0_in.last = (n_in == 2'd1);
      r1_in.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cur_ff   <= 13'd0;
         total_ff <= 14'd0;
         wait_ff  <= 19'd0;
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            cur_ff   <= cur_in;
            total_ff <= total_in;
            wait_ff  <= wait_in;
         end
         if (take) begin
            v0_ff <= (n_in != 2'd0);
            v1_ff <= (n_in == 2'd2);
         end else if (out_valid && out_ready) begin
            v0_ff <= v1_ff;
            v1_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         r0_ff <= r0_in;
         r1_ff <= r1_in;
      end else if (out_valid && out_ready) begin
         r0_ff <= r1_ff;
      end
   end

   assert property (@(posedge clock) disable iff (reset) v1_ff |-> v0_ff)
      else $error("second slot valid without first");
   assert property (@(posedge clock) disable iff (reset)
      (v0_ff && !v1_ff) |-> r0_ff.last) else $error("sole result lacks last");
   assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_FAIL_LATE) else $error("phase out of range");
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PACKET) |-> ({1'b0, cur_ff} < total_ff || total_ff == 14'd0))
      else $error("packet number beyond count");
endmodule
`default_nettype wire

// ----- src/ota_transfer_sequencer.sv -----
`default_nettype none
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_ready   event fields
// rsp_      out        rsp_valid / rsp_ready   command and result fields
// csr_      in         csr_write               csr_index, csr_data
//
// One event per cycle sustained while results are taken. A classified event
// waits in a two-entry queue; the sequencer's result is registered in the cycle
// after it takes the event. Abort yields up to two results, delivered in order
// from the output register pair; the sequencer stalls while a held result is
// not taken or both slots are full, and req_ready drops once the queue holds two
// events. Synchronous active-high reset clears phase, counters and valid flags.
module ota_transfer_sequencer #(
   parameter int unsigned PACKET_BYTES = ots_pkg::PACKET_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_operation,
   input  wire logic        req_resp_is_note,
   input  wire logic [2:0]  req_resp_message,
   input  wire logic        req_resp_ok,
   input  wire logic [1:0]  req_module_status,
   input  wire logic [31:0] req_echoed_packet,
   input  wire logic [2:0]  req_transfer_status,
   input  wire logic [12:0] req_wanted_packet,
   input  wire logic        req_upgrade_ok,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_command,
   output      logic [12:0] rsp_packet_number,
   output      logic [23:0] rsp_payload_offset,
   output      logic [11:0] rsp_payload_length,
   output      logic [13:0] rsp_packet_count,
   output      logic [1:0]  rsp_outcome,
   output      logic [3:0]  rsp_fail_cause,
   output      logic        rsp_last,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data
);
   ots_pkg::event_type  evt;
   ots_pkg::result_type res;
   logic evt_valid, evt_ready;

   ots_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_operation, .req_resp_is_note,
      .req_resp_message, .req_resp_ok, .req_module_status, .req_echoed_packet,
      .req_transfer_status, .req_wanted_packet, .req_upgrade_ok,
      .evt_valid, .evt_ready, .evt_data(evt)
   );

   ots_back #(.PACKET_BYTES(PACKET_BYTES)) u_back (
      .clock, .reset, .evt_valid, .evt_ready, .evt_data(evt),
      .csr_write, .csr_index, .csr_data,
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(res)
   );

   assign rsp_command        = res.command;
   assign rsp_packet_number  = res.packet_number;
   assign rsp_payload_offset = res.payload_offset;
   assign rsp_payload_length = res.payload_length;
   assign rsp_packet_count   = res.packet_count;
   assign rsp_outcome        = res.outcome;
   assign rsp_fail_cause     = res.fail_cause;
   assign rsp_last           = res.last;
endmodule
`default_nettype wire
